/* rtl/ssm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring matcher package
// Shared types, register codes and byte helpers for the substring matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int PATTERN_MAX_DEFAULT    = 16;
    localparam int POSITION_WIDTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH            = 4;
    localparam int CFG_INDEX_WIDTH        = 2;
    localparam int CFG_DATA_WIDTH         = 64;
    localparam int LENGTH_WIDTH           = 5;
    localparam int MATCH_POS_WIDTH        = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_IGNORE_CASE  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic                       found;
        logic [MATCH_POS_WIDTH-1:0] match_position;
        logic                       position_saturated;
    } t_result;

    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] pattern_low_bytes;
        logic [CFG_DATA_WIDTH-1:0] pattern_high_bytes;
        logic [LENGTH_WIDTH-1:0]   pattern_length;
        logic                      ignore_case;
    } t_cfg;

    function automatic logic [7:0] fold_byte(input logic ic, input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (ic && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] pattern_byte(input t_cfg cfg, input logic [3:0] idx);
        logic [CFG_DATA_WIDTH-1:0] word;
        word = idx[3] ? cfg.pattern_high_bytes : cfg.pattern_low_bytes;
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

/* rtl/ssm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring matcher front end
// Until a match, shifts each byte into the window, compares it against
// the pattern and classifies the byte as match, not-found or silent.
// ----------------------------------------------------------------------------
module ssm_front #(
    parameter int PATTERN_MAX    = ssm_pkg::PATTERN_MAX_DEFAULT,
    parameter int POSITION_WIDTH = ssm_pkg::POSITION_WIDTH_DEFAULT
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire ssm_pkg::t_item  i_item,
    input  wire ssm_pkg::t_cfg   i_cfg,
    output logic                 o_push,
    output ssm_pkg::t_result     o_result
);
    import ssm_pkg::*;

    localparam int EW = (POSITION_WIDTH > LENGTH_WIDTH) ? POSITION_WIDTH : LENGTH_WIDTH;
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    logic [7:0]                r_win [PATTERN_MAX];
    logic [7:0]                n_win [PATTERN_MAX];
    logic [POSITION_WIDTH-1:0] r_count, n_count;
    logic                      r_reported, n_reported;
    logic                      r_sat, n_sat;

    logic [LENGTH_WIDTH-1:0]   len;
    logic                      sat_now;
    logic                      reach;
    logic                      all_eq;
    logic                      hit;
    logic [7:0]                sel;
    logic [EW-1:0]             pos_full;

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            len = LENGTH_WIDTH'(1);
        end else if (i_cfg.pattern_length > LENGTH_WIDTH'(PATTERN_MAX)) begin
            len = LENGTH_WIDTH'(PATTERN_MAX);
        end else begin
            len = i_cfg.pattern_length;
        end

        n_win[0] = i_item.source_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end

        all_eq = 1'b1;
        sel    = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (LENGTH_WIDTH'(k) < len) begin
                sel = '0;
                for (int j = 0; j < PATTERN_MAX; j++) begin
                    if (LENGTH_WIDTH'(j) == len - LENGTH_WIDTH'(1) - LENGTH_WIDTH'(k)) begin
                        sel = n_win[j];
                    end
                end
                if (fold_byte(i_cfg.ignore_case, pattern_byte(i_cfg, 4'(k)))
                        != fold_byte(i_cfg.ignore_case, sel)) begin
                    all_eq = 1'b0;
                end
            end
        end

        sat_now  = r_sat | (r_count == POS_MAX);
        reach    = EW'(r_count) >= EW'(len - LENGTH_WIDTH'(1));
        hit      = reach & all_eq;
        pos_full = EW'(r_count) - EW'(len - LENGTH_WIDTH'(1));

        o_push = i_accept & ~r_reported & (hit | i_item.last_byte);
        o_result.found              = hit;
        o_result.match_position     = hit ? MATCH_POS_WIDTH'(pos_full) : '0;
        o_result.position_saturated = sat_now;

        n_count    = r_count;
        n_reported = r_reported;
        n_sat      = r_sat;
        if (i_accept) begin
            if (!r_reported) begin
                n_sat      = sat_now;
                n_count    = sat_now ? r_count : r_count + POSITION_WIDTH'(1);
                n_reported = hit;
            end
            if (i_item.last_byte) begin
                n_count    = '0;
                n_reported = 1'b0;
                n_sat      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_reported) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_reported <= 1'b0;
            r_sat      <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_reported <= n_reported;
            r_sat      <= n_sat;
        end
    end

endmodule
`default_nettype wire

/* rtl/ssm_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring matcher result queue
// Holds classified results until the consumer pops them.
// ----------------------------------------------------------------------------
module ssm_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ssm_pkg::t_result i_result,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output ssm_pkg::t_result      o_result
);
    import ssm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result         r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            pop_ok;

    always_comb begin
        o_full   = (r_cnt == CW'(QUEUE_DEPTH));
        o_empty  = (r_cnt == '0);
        o_result = r_mem[r_rd];
        pop_ok   = i_pop & ~o_empty;

        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !pop_ok) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && pop_ok) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

/* rtl/streaming_substring_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle while the result queue is not full; the full window
// compare runs in the push cycle; any result it yields is registered into the queue.
// A four-entry result queue decouples the compare from the consumer.
// Reset (synchronous, active low) empties the queue, restarts the string
// and restores the pattern registers to their reset values.
// ----------------------------------------------------------------------------
// Streaming substring matcher
// Finds the first occurrence of a configured pattern in each string of a byte stream.
// ----------------------------------------------------------------------------
module streaming_substring_matcher #(
    parameter int PATTERN_MAX    = ssm_pkg::PATTERN_MAX_DEFAULT,
    parameter int POSITION_WIDTH = ssm_pkg::POSITION_WIDTH_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire ssm_pkg::t_item                      i_item,
    output logic                                     empty,
    input  wire logic                                pop,
    output ssm_pkg::t_result                         o_result,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ssm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [ssm_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);
    import ssm_pkg::*;

    t_cfg    r_cfg;
    logic    accept;
    logic    front_push;
    t_result front_result;

    assign o_cfg_ready = 1'b1;
    assign accept      = push & ~full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low_bytes  <= '0;
            r_cfg.pattern_high_bytes <= '0;
            r_cfg.pattern_length     <= LENGTH_WIDTH'(1);
            r_cfg.ignore_case        <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LOW:  r_cfg.pattern_low_bytes  <= i_cfg_data;
                REG_PATTERN_HIGH: r_cfg.pattern_high_bytes <= i_cfg_data;
                REG_PATTERN_LEN:  r_cfg.pattern_length     <= i_cfg_data[LENGTH_WIDTH-1:0];
                REG_IGNORE_CASE:  r_cfg.ignore_case        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ssm_front #(
        .PATTERN_MAX    (PATTERN_MAX),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_push   (front_push),
        .o_result (front_result)
    );

    ssm_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_result (front_result),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

/* rtl/ssm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring matcher port checker
// Watches the top-level ports for queue and result consistency.
// ----------------------------------------------------------------------------
module ssm_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             push,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire ssm_pkg::t_result o_result
);
    import ssm_pkg::*;

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue reports full and empty together");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.found) |-> (o_result.match_position == '0))
        else $error("not-found result carries a nonzero position");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result appeared without a request");

    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed before pop");

endmodule

bind streaming_substring_matcher ssm_checker u_ssm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
`default_nettype wire

/* tb/sv/streaming_substring_matcher_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming substring matcher testbench
// Streams byte strings into the matcher under a series of pattern settings and
// checks every start-position and not-found result against a local predictor.
// Requests are offered in random bursts and results drained with random stalls,
// including one long drain hold-off that fills the block.
// ----------------------------------------------------------------------------
module streaming_substring_matcher_test;

    import ssm_pkg::*;

    localparam int          WINDOW       = 16;
    localparam logic [31:0] INDEX_MAX    = '1;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 4;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       push        = 1'b0;
    logic                       full;
    t_item                      i_item      = '0;
    logic                       empty;
    logic                       pop         = 1'b0;
    t_result                    o_result;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data  = '0;

    streaming_substring_matcher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // pattern registers as the matcher holds them
    logic [63:0] pat_lo    = '0;
    logic [63:0] pat_hi    = '0;
    logic [4:0]  pat_len   = 5'd1;
    logic        fold_case = 1'b0;

    // per-string search state
    logic [7:0]  window [WINDOW];
    logic [31:0] byte_index;
    logic        seen_match;
    logic        index_stuck;

    t_item   pending_items[$];
    t_result expected_results[$];

    int error_count  = 0;
    int n_bytes_sent = 0;
    int n_strings    = 0;
    int n_found      = 0;
    int n_missing    = 0;
    int n_settings   = 0;
    int holds_wanted = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] folded(input logic [7:0] c);
        return (fold_case && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] stored_byte(input int k);
        return (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
    endfunction

    task automatic clear_string();
        for (int k = 0; k < WINDOW; k++) window[k] = 8'h00;
        byte_index  = '0;
        seen_match  = 1'b0;
        index_stuck = 1'b0;
    endtask

    task automatic predict_result(input t_item it);
        int          len;
        logic [31:0] idx;
        logic        hit;
        t_result     r;
        if (!seen_match) begin
            len = (pat_len == 0) ? 1 : ((pat_len > WINDOW) ? WINDOW : int'(pat_len));
            for (int k = WINDOW - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = it.source_byte;
            idx = byte_index;
            if (idx == INDEX_MAX) index_stuck = 1'b1;
            hit = (idx >= len - 1);
            for (int k = 0; k < len; k++) begin
                if (folded(stored_byte(k)) != folded(window[len-1-k])) hit = 1'b0;
            end
            if (!index_stuck) byte_index = idx + 1;
            r = '0;
            r.position_saturated = index_stuck;
            if (hit) begin
                r.found          = 1'b1;
                r.match_position = idx - (len - 1);
                seen_match       = 1'b1;
                expected_results.push_back(r);
            end else if (it.last_byte) begin
                expected_results.push_back(r);
            end
        end
        if (it.last_byte) clear_string();
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: result with nothing pending, actual %p", $time, got);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
                error_count++;
            end
            if (got.match_position !== want.match_position) begin
                $display("%0t: match_position expected %0d actual %0d",
                         $time, want.match_position, got.match_position);
                error_count++;
            end
            if (got.position_saturated !== want.position_saturated) begin
                $display("%0t: position_saturated expected %0b actual %0b",
                         $time, want.position_saturated, got.position_saturated);
                error_count++;
            end
            if (want.found) n_found++;
            else n_missing++;
        end
    endtask

    // request driver: random bursts and gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_result(i_item);
                void'(pending_items.pop_front());
                n_bytes_sent++;
                if (i_item.last_byte) n_strings++;
                if (burst_left > 0) burst_left--;
            end
            if (!(push && full)) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    push   <= 1'b1;
                    i_item <= pending_items[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor: own stall pattern plus a long hold-off on request
    int ready_left   = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int holds_served = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_result(o_result);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (holds_served != holds_wanted) begin
                holds_served = holds_wanted;
                hold_left    = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                if (ready_left == 0 && stall_left == 0) begin
                    ready_left = $urandom_range(1, 16);
                    stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (ready_left > 0) begin
                    ready_left--;
                    pop <= 1'b1;
                end else begin
                    stall_left--;
                    pop <= 1'b0;
                end
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_reg code, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= code;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (code)
            REG_PATTERN_LOW:  pat_lo    = value;
            REG_PATTERN_HIGH: pat_hi    = value;
            REG_PATTERN_LEN:  pat_len   = value[4:0];
            REG_IGNORE_CASE:  fold_case = value[0];
            default: ;
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b, input logic closes);
        t_item it;
        it.source_byte = b;
        it.last_byte   = closes;
        pending_items.push_back(it);
    endtask

    task automatic add_text(input string s, input logic closes);
        for (int k = 0; k < s.len(); k++) add_byte(s[k], closes && k == s.len() - 1);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte(input int kind);
        logic [7:0] c;
        case (kind)
            0: c = (8'h41 + $urandom_range(0, 1)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
            1: c = $urandom_range(0, 255);
            2: c = (8'h41 + $urandom_range(0, 25)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
            default: begin
                case ($urandom_range(0, 7))
                    0: c = 8'h40;
                    1: c = 8'h41;
                    2: c = 8'h5A;
                    3: c = 8'h5B;
                    4: c = 8'h60;
                    5: c = 8'h61;
                    6: c = 8'h7A;
                    default: c = 8'h7B;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c, input logic ic);
        logic is_letter;
        is_letter = ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A);
        if (is_letter && $urandom_range(0, 9) < (ic ? 5 : 1)) return c ^ 8'h20;
        return c;
    endfunction

    task automatic random_phase(input int phase_no, input int n_bytes, input logic short_strings);
        logic [7:0] pat [WINDOW];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0] str[$];
        logic        ic;
        int          len_code;
        int          eff;
        int          kind;
        int          shape;
        int          queued;
        int          n_plant;
        case (phase_no)
            0: len_code = 1;
            1: len_code = 16;
            2: len_code = 0;
            3: len_code = 31;
            4: len_code = 2;
            5: len_code = 17;
            default: len_code = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(1, 6);
        endcase
        eff  = (len_code == 0) ? 1 : ((len_code > WINDOW) ? WINDOW : len_code);
        kind = $urandom_range(0, 3);
        ic   = $urandom_range(0, 1);
        for (int k = 0; k < WINDOW; k++) begin
            if (phase_no == 0) pat[k] = 8'h00;
            else if (phase_no == 1) pat[k] = 8'hFF;
            else pat[k] = pick_byte(kind);
        end
        for (int k = 0; k < 8; k++) begin
            lo[k*8 +: 8] = pat[k];
            hi[k*8 +: 8] = pat[k+8];
        end
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LEN, 64'(len_code));
        write_reg(REG_IGNORE_CASE, 64'(ic));
        i_cfg_valid <= 1'b0;
        n_settings++;
        if (short_strings) holds_wanted <= holds_wanted + 1;
        queued = 0;
        while (queued < n_bytes) begin
            str.delete();
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                repeat ($urandom_range(1, 20)) str.push_back($urandom_range(0, 255));
            end else begin
                repeat (short_strings ? $urandom_range(0, 2) : $urandom_range(0, 12))
                    str.push_back(pick_byte(kind));
                if (shape <= 7) begin
                    n_plant = (shape == 7) ? eff - 1 : eff;
                    for (int k = 0; k < n_plant; k++) str.push_back(vary_case(pat[k], ic));
                end
                if (!short_strings) begin
                    repeat ($urandom_range(0, 5)) str.push_back(pick_byte(kind));
                end
            end
            if (str.size() == 0) str.push_back(pick_byte(kind));
            for (int k = 0; k < str.size(); k++) add_byte(str[k], k == str.size() - 1);
            queued += str.size();
        end
        wait_idle();
    endtask

    initial begin
        clear_string();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pattern is one zero byte
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b1);
        wait_idle();

        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0062_6161);
        write_reg(REG_PATTERN_HIGH, '1);
        write_reg(REG_PATTERN_LEN, 64'd3);
        write_reg(REG_IGNORE_CASE, 64'd0);
        i_cfg_valid <= 1'b0;
        n_settings++;
        add_text("aaab", 1'b1);
        add_text("AaB", 1'b1);
        add_text("ab", 1'b1);
        wait_idle();

        write_reg(REG_IGNORE_CASE, 64'd1);
        i_cfg_valid <= 1'b0;
        n_settings++;
        add_text("aAB", 1'b1);
        add_text("x", 1'b0);
        wait_idle();

        // change pattern in the middle of a string
        write_reg(REG_PATTERN_LOW, 64'h5B);
        write_reg(REG_PATTERN_LEN, 64'd0);
        i_cfg_valid <= 1'b0;
        n_settings++;
        add_text("{[", 1'b1);
        wait_idle();

        for (int p = 0; p < 9; p++) begin
            random_phase(p, (p == 4) ? 50 : 60, p == 4);
        end

        $display("covered %0d bytes in %0d strings under %0d pattern settings",
                 n_bytes_sent, n_strings, n_settings);
        $display("checked %0d results: %0d matches, %0d strings without a match",
                 n_found + n_missing, n_found, n_missing);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
